// ----- design/socd_pkg.sv -----
// Package with the shared types, codes and field widths of the SOCD report resolver.
`default_nettype none
package socd_pkg;

	localparam int KEY_W = 35;
	localparam int DPAD_W = 4;
	localparam int PAD_W = 22;
	localparam int CMD_W = 3;
	localparam int IDX_W = 6;
	localparam int IDX_SPACE = 64;
	localparam int PAD_LSB = 4;

	localparam int BIT_RIGHT = 0;
	localparam int BIT_LEFT = 1;
	localparam int BIT_UP = 2;
	localparam int BIT_DOWN = 3;

	localparam logic [CMD_W-1:0] CMD_PRESS = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RELEASE_ALL = 3'd2;
	localparam logic [CMD_W-1:0] CMD_TOGGLE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SEND = 3'd4;

	localparam logic [1:0] RES_BOTH = 2'd0;
	localparam logic [1:0] RES_CANCEL = 2'd1;
	localparam logic [1:0] RES_UP_PRIORITY = 2'd2;
	localparam logic [1:0] RES_LATEST = 2'd3;

	localparam logic OUT_KEYBOARD = 1'b0;
	localparam logic OUT_GAMEPAD = 1'b1;

	localparam logic [DPAD_W-1:0] HAT_CENTER = 4'd0;
	localparam logic [DPAD_W-1:0] HAT_N = 4'd1;
	localparam logic [DPAD_W-1:0] HAT_NE = 4'd2;
	localparam logic [DPAD_W-1:0] HAT_E = 4'd3;
	localparam logic [DPAD_W-1:0] HAT_SE = 4'd4;
	localparam logic [DPAD_W-1:0] HAT_S = 4'd5;
	localparam logic [DPAD_W-1:0] HAT_SW = 4'd6;
	localparam logic [DPAD_W-1:0] HAT_W = 4'd7;
	localparam logic [DPAD_W-1:0] HAT_NW = 4'd8;

	localparam int FLAG_LEFT_FIRST = 0;
	localparam int FLAG_RIGHT_FIRST = 1;
	localparam int FLAG_BOTH = 2;

	localparam logic REG_SOCD_MODE = 1'b0;
	localparam logic REG_OUTPUT_MODE = 1'b1;

	typedef struct packed {
		logic [1:0] socd_mode;
		logic       output_mode;
	} cfg_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key_mask;
		logic [DPAD_W-1:0] dpad_code;
		logic [PAD_W-1:0]  pad_buttons;
	} report_t;

endpackage
`default_nettype wire

// ----- design/socd_if.sv -----
// Stream interfaces for the command channel and the report channel.
`default_nettype none
interface socd_cmd_if;
	import socd_pkg::*;
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic [IDX_W-1:0] button_index;
	modport source (output valid, command, button_index, input ready);
	modport sink (input valid, command, button_index, output ready);
endinterface

interface socd_rpt_if;
	import socd_pkg::*;
	logic              valid;
	logic              ready;
	logic [KEY_W-1:0]  key_mask;
	logic [DPAD_W-1:0] dpad_code;
	logic [PAD_W-1:0]  pad_buttons;
	modport source (output valid, key_mask, dpad_code, pad_buttons, input ready);
	modport sink (input valid, key_mask, dpad_code, pad_buttons, output ready);
endinterface
`default_nettype wire

// ----- design/socd_cfg.sv -----
// APB-style register file holding the SOCD mode and the output mode.
`default_nettype none
module socd_cfg (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output socd_pkg::cfg_t    cfg
);
	import socd_pkg::*;

	logic [1:0] socd_mode_q;
	logic       output_mode_q;
	logic       reg_sel;
	logic       wr_en;

	assign reg_sel = paddr[2];
	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			socd_mode_q <= RES_BOTH;
			output_mode_q <= OUT_KEYBOARD;
		end else if (wr_en) begin
			case (reg_sel)
				REG_SOCD_MODE: socd_mode_q <= pwdata[1:0];
				REG_OUTPUT_MODE: output_mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SOCD_MODE: prdata = {30'd0, socd_mode_q};
			REG_OUTPUT_MODE: prdata = {31'd0, output_mode_q};
			default: prdata = 32'd0;
		endcase
	end

	assign cfg = '{socd_mode: socd_mode_q, output_mode: output_mode_q};
endmodule
`default_nettype wire

// ----- design/socd_held.sv -----
// Held-button register updated by press, release, release-all and toggle commands.
`default_nettype none
module socd_held #(
	parameter int NUM_BUTTONS = 35
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_fire,
	input  wire logic [socd_pkg::CMD_W-1:0]    command,
	input  wire logic [socd_pkg::IDX_W-1:0]    button_index,
	output logic [NUM_BUTTONS-1:0]             held
);
	import socd_pkg::*;

	logic [NUM_BUTTONS-1:0] held_q;
	logic [NUM_BUTTONS-1:0] sel;
	logic [NUM_BUTTONS-1:0] held_nxt;

	always_comb begin
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			sel[i] = (button_index == IDX_W'(i));
		end
	end

	always_comb begin
		case (command)
			CMD_PRESS: held_nxt = held_q | sel;
			CMD_RELEASE: held_nxt = held_q & ~sel;
			CMD_RELEASE_ALL: held_nxt = '0;
			CMD_TOGGLE: held_nxt = held_q ^ sel;
			default: held_nxt = held_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (cmd_fire) begin
			held_q <= held_nxt;
		end
	end

	assign held = held_q;
endmodule
`default_nettype wire

// ----- design/socd_resolve.sv -----
// Direction resolution, last-input flags and report formatting for one send beat.
`default_nettype none
module socd_resolve #(
	parameter int NUM_BUTTONS = 35
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  send_fire,
	input  wire logic [NUM_BUTTONS-1:0] held,
	input  wire socd_pkg::cfg_t        cfg,
	output socd_pkg::report_t          report
);
	import socd_pkg::*;

	logic [2:0]           flags_q [2];
	logic [2:0]           f_in;
	logic [2:0]           f_set;
	logic [2:0]           f_nxt;
	logic [IDX_SPACE-1:0] hx;
	logic                 l, r, u, d;
	logic                 li_xp, li_xn;
	logic                 xp, xn, yp, yn;
	logic                 kbd_natural;
	logic [DPAD_W-1:0]    dpad;

	assign hx = IDX_SPACE'(held);
	assign r = hx[BIT_RIGHT];
	assign l = hx[BIT_LEFT];
	assign u = hx[BIT_UP];
	assign d = hx[BIT_DOWN];
	assign kbd_natural = (cfg.socd_mode == RES_BOTH) && (cfg.output_mode == OUT_KEYBOARD);
	assign f_in = flags_q[cfg.output_mode];

	always_comb begin
		f_set = f_in;
		if (f_in == 3'd0) begin
			if (l && r) f_set[FLAG_BOTH] = 1'b1;
			else if (l) f_set[FLAG_LEFT_FIRST] = 1'b1;
			else if (r) f_set[FLAG_RIGHT_FIRST] = 1'b1;
		end
		f_nxt = f_set;
		li_xp = 1'b0;
		li_xn = 1'b0;
		if (f_set[FLAG_BOTH]) begin
			if (!l || !r) f_nxt[FLAG_BOTH] = 1'b0;
		end else if (f_set[FLAG_LEFT_FIRST]) begin
			if (!l) f_nxt[FLAG_LEFT_FIRST] = 1'b0;
			li_xp = r;
			li_xn = !r && l;
		end else if (f_set[FLAG_RIGHT_FIRST]) begin
			if (!r) f_nxt[FLAG_RIGHT_FIRST] = 1'b0;
			li_xn = l;
			li_xp = !l && r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q[0] <= '0;
			flags_q[1] <= '0;
		end else if (send_fire && cfg.socd_mode == RES_LATEST) begin
			flags_q[cfg.output_mode] <= f_nxt;
		end
	end

	always_comb begin
		if (cfg.socd_mode == RES_LATEST) begin
			xp = li_xp;
			xn = li_xn;
		end else if (kbd_natural) begin
			xp = r;
			xn = l;
		end else begin
			xp = r && !l;
			xn = l && !r;
		end
		if (cfg.socd_mode == RES_UP_PRIORITY || cfg.socd_mode == RES_LATEST) begin
			yp = u;
			yn = !u && d;
		end else if (!kbd_natural) begin
			yp = u && !d;
			yn = d && !u;
		end else begin
			yp = 1'b0;
			yn = 1'b0;
		end
	end

	always_comb begin
		if (xn) dpad = yn ? HAT_SW : (yp ? HAT_NW : HAT_W);
		else if (!xp) dpad = yn ? HAT_S : (yp ? HAT_N : HAT_CENTER);
		else dpad = yn ? HAT_SE : (yp ? HAT_NE : HAT_E);
	end

	always_comb begin
		if (cfg.output_mode == OUT_KEYBOARD) begin
			report.key_mask = {hx[KEY_W-1:4],
				(cfg.socd_mode == RES_BOTH) ? hx[3:0] : {yn, yp, xn, xp}};
			report.dpad_code = HAT_CENTER;
			report.pad_buttons = '0;
		end else begin
			report.key_mask = '0;
			report.dpad_code = dpad;
			report.pad_buttons = hx[PAD_LSB +: PAD_W];
		end
	end
endmodule
`default_nettype wire

// ----- design/socd_button_report_resolver_unit.sv -----
// Top level of the SOCD button report resolver with its report output register.
// A new command beat can be taken in every cycle while no report waits or the report channel's
// ready is high. Press, release, release-all and toggle update the held-button register at
// the accepting edge; a send beat produces one report in the output register in the cycle
// after, resolved from the held buttons, the SOCD mode and the last-input flags. Registers
// must be written over the APB-style port only while no beat is in flight; the block
// itself does not enforce this.
`default_nettype none
module socd_button_report_resolver_unit #(
	parameter int NUM_BUTTONS = 35
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	socd_cmd_if.sink         in_ch,
	socd_rpt_if.source       out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	import socd_pkg::*;

	cfg_t                   cfg;
	report_t                report;
	report_t                report_q;
	logic                   out_valid_q;
	logic                   cmd_fire;
	logic                   send_fire;
	logic [NUM_BUTTONS-1:0] held;

	socd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign cmd_fire = in_ch.valid && in_ch.ready;
	assign send_fire = cmd_fire && (in_ch.command == CMD_SEND);

	socd_held #(.NUM_BUTTONS(NUM_BUTTONS)) u_held (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_fire     (cmd_fire),
		.command      (in_ch.command),
		.button_index (in_ch.button_index),
		.held         (held)
	);

	socd_resolve #(.NUM_BUTTONS(NUM_BUTTONS)) u_resolve (
		.clk       (clk),
		.arst_n    (arst_n),
		.send_fire (send_fire),
		.held      (held),
		.cfg       (cfg),
		.report    (report)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (send_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (send_fire) begin
			report_q <= report;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.key_mask = report_q.key_mask;
	assign out_ch.dpad_code = report_q.dpad_code;
	assign out_ch.pad_buttons = report_q.pad_buttons;

`ifndef SYNTHESIS
	a_send_gives_report: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && in_ch.command == CMD_SEND) |=> out_ch.valid)
		else $error("Accepted send beat did not produce a report.");

	a_no_invented_report: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_ch.valid && !(in_ch.valid && in_ch.ready && in_ch.command == CMD_SEND))
		|=> !out_ch.valid)
		else $error("Report appeared without a send beat.");

	a_mode_fields_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.key_mask != '0)
		|-> (out_ch.dpad_code == HAT_CENTER && out_ch.pad_buttons == '0))
		else $error("Keyboard report carries gamepad fields.");

	a_dpad_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.dpad_code <= HAT_NW))
		else $error("Dpad code out of range.");
`endif
endmodule
`default_nettype wire
